@@ hw/rtl/assert_macros.svh @@
// Assertion helpers used by the deframer core.
// Each macro expects a clock named clk and an active-low reset named rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPLY(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication.
`define ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

@@ hw/rtl/pfd_pkg.sv @@
// ---------------------------------------------------------------------------
// pfd_pkg
// Types and constants of the pose frame deframer.
// ---------------------------------------------------------------------------
package pfd_pkg;

    localparam int FRAME_BYTES = 28;
    localparam int BURST_LIMIT = 32;
    localparam int CNT_W       = $clog2(BURST_LIMIT + 1);

    localparam logic [7:0] HDR0  = 8'h0D;
    localparam logic [7:0] HDR1  = 8'h0A;
    localparam logic [7:0] TAIL0 = 8'h0A;
    localparam logic [7:0] TAIL1 = 8'h0D;

    localparam logic       CMD_BYTE = 1'b0;
    localparam logic       CMD_IDLE = 1'b1;

    // Magnitudes of 135.0 and infinity, and exponent and mantissa of 360.0, as single precision fields.
    localparam logic [30:0] MAG_135  = 31'h43070000;
    localparam logic [30:0] MAG_INF  = 31'h7F800000;
    localparam logic [7:0]  EXP_360  = 8'd135;
    localparam logic [23:0] MANT_360 = 24'hB40000;

    typedef struct packed {
        logic       command;
        logic [7:0] rx_byte;
    } in_item_t;

    typedef struct packed {
        logic [31:0] yaw_bits;
        logic [31:0] pitch_bits;
        logic [31:0] roll_bits;
        logic [31:0] pos_x_bits;
        logic [31:0] pos_y_bits;
        logic [31:0] rate_z_bits;
        logic        tail_ok;
    } out_item_t;

endpackage

@@ hw/rtl/pose_frame_deframer_core.sv @@
// ---------------------------------------------------------------------------
// pose_frame_deframer_core
// Deframes fixed-length pose frames from a UART byte stream.
// ---------------------------------------------------------------------------
// The block takes one request per cycle: a received byte or a line-idle event.
// Bytes shift into a chain of 28 byte cells while the burst count is below
// 28. An idle event after exactly 28 bytes with header 0x0D 0x0A sends the
// frame into a five-stage single-precision pipeline that wraps finite yaw
// values below -135.0 by adding 360.0. Input is refused only while all five
// pipeline stages are full and the output is not taken.
`include "assert_macros.svh"

module pose_frame_deframer_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  pfd_pkg::in_item_t  in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output pfd_pkg::out_item_t out_data
);
    import pfd_pkg::*;

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             in_fire;
    logic             shift_en;
    logic [7:0]       cell_q [FRAME_BYTES];
    logic [7:0]       fb     [FRAME_BYTES];
    logic             frame_good;
    logic             pipe_ready;
    out_item_t        frame_item;

    assign in_fire  = in_valid && in_ready;
    assign shift_en = in_fire && (in_data.command == CMD_BYTE)
                      && (count_reg < CNT_W'(FRAME_BYTES));

    for (genvar i = 0; i < FRAME_BYTES; i++)
    begin : g_cell
        pfd_byte_cell u_cell (
            .clk      (clk),
            .shift_en (shift_en),
            .data_in  ((i == 0) ? in_data.rx_byte : cell_q[(i == 0) ? 0 : i - 1]),
            .data_out (cell_q[i])
        );
        // The first byte of the burst has travelled to the far end of the chain.
        assign fb[i] = cell_q[FRAME_BYTES - 1 - i];
    end

    always_comb
    begin
        count_next = count_reg;
        if (in_fire)
        begin
            if (in_data.command == CMD_IDLE)
            begin
                count_next = '0;
            end
            else if (count_reg < CNT_W'(BURST_LIMIT))
            begin
                count_next = count_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_comb
    begin
        frame_good = (in_data.command == CMD_IDLE) && (count_reg == CNT_W'(FRAME_BYTES))
                     && (fb[0] == HDR0) && (fb[1] == HDR1);
        frame_item.yaw_bits    = {fb[5],  fb[4],  fb[3],  fb[2]};
        frame_item.pitch_bits  = {fb[9],  fb[8],  fb[7],  fb[6]};
        frame_item.roll_bits   = {fb[13], fb[12], fb[11], fb[10]};
        frame_item.pos_x_bits  = {fb[17], fb[16], fb[15], fb[14]};
        frame_item.pos_y_bits  = {fb[21], fb[20], fb[19], fb[18]};
        frame_item.rate_z_bits = {fb[25], fb[24], fb[23], fb[22]};
        frame_item.tail_ok     = (fb[26] == TAIL0) && (fb[27] == TAIL1);
    end

    pfd_wrap_pipe u_pipe (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid && frame_good),
        .in_ready  (pipe_ready),
        .in_data   (frame_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    assign in_ready = pipe_ready;

    `ASSERT_IMPLY(a_stall_only_when_blocked, !in_ready, out_valid && !out_ready)
    `ASSERT_NEXT(a_idle_clears_count, in_fire && (in_data.command == CMD_IDLE), count_reg == '0)
    `ASSERT_NEXT(a_byte_counts, shift_en, count_reg == $past(count_reg) + CNT_W'(1))
endmodule

@@ hw/rtl/pfd_byte_cell.sv @@
// ---------------------------------------------------------------------------
// pfd_byte_cell
// One byte of the frame shift chain; loads its neighbor's byte on a shift.
// ---------------------------------------------------------------------------
module pfd_byte_cell (
    input  logic       clk,
    input  logic       shift_en,
    input  logic [7:0] data_in,
    output logic [7:0] data_out
);
    logic [7:0] byte_reg;
    logic [7:0] byte_next;

    always_comb
    begin
        byte_next = shift_en ? data_in : byte_reg;
    end

    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
    end

    assign data_out = byte_reg;
endmodule

@@ hw/rtl/pfd_wrap_pipe.sv @@
// ---------------------------------------------------------------------------
// pfd_wrap_pipe
// Five-stage elastic pipeline that adds 360.0 to finite yaw values below -135.0.
// ---------------------------------------------------------------------------
module pfd_wrap_pipe (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  pfd_pkg::out_item_t in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output pfd_pkg::out_item_t out_data
);
    import pfd_pkg::*;

    logic [4:0] vld_reg;
    logic [4:0] vld_next;
    logic [4:0] adv;
    out_item_t  pay_reg [5];

    // Stage 2: ordered operands.
    logic        wrap2_reg, inf2_reg, sign2_reg;
    logic [23:0] big2_reg;
    logic [26:0] small2_reg;
    logic [7:0]  exp2_reg;
    // Stage 3: difference.
    logic        wrap3_reg, inf3_reg, sign3_reg;
    logic [26:0] diff3_reg;
    logic [7:0]  exp3_reg;
    // Stage 4: leading zero count.
    logic        wrap4_reg, inf4_reg, sign4_reg, zero4_reg;
    logic [26:0] diff4_reg;
    logic [7:0]  exp4_reg;
    logic [4:0]  lzc4_reg;

    // Handshake: a stage moves when it is empty or the next one moves.
    always_comb
    begin
        adv[4] = !vld_reg[4] || out_ready;
        for (int i = 3; i >= 0; i--)
        begin
            adv[i] = !vld_reg[i] || adv[i+1];
        end
        vld_next[0] = adv[0] ? in_valid : vld_reg[0];
        for (int i = 1; i < 5; i++)
        begin
            vld_next[i] = adv[i] ? vld_reg[i-1] : vld_reg[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            pay_reg[0] <= in_data;
        end
        for (int i = 1; i < 5; i++)
        begin
            if (adv[i])
            begin
                pay_reg[i] <= pay_reg[i-1];
            end
        end
    end

    // Stage 2 logic: order magnitudes of |yaw| and 360, align the smaller.
    logic [31:0] y1;
    logic [7:0]  ea;
    logic [23:0] ma;
    logic        a_big;
    logic [23:0] big_m, small_m;
    logic [7:0]  big_e, align_sh;
    logic [26:0] ext, shifted, lost_mask;
    logic        sticky;

    always_comb
    begin
        y1    = pay_reg[0].yaw_bits;
        ea    = y1[30:23];
        ma    = {1'b1, y1[22:0]};
        a_big = (ea > EXP_360) || ((ea == EXP_360) && (ma >= MANT_360));
        if (a_big)
        begin
            big_m    = ma;
            big_e    = ea;
            small_m  = MANT_360;
            align_sh = ea - EXP_360;
        end
        else
        begin
            big_m    = MANT_360;
            big_e    = EXP_360;
            small_m  = ma;
            align_sh = EXP_360 - ea;
        end
        ext = {small_m, 3'b000};
        if (align_sh >= 8'd27)
        begin
            shifted = '0;
            sticky  = 1'b1;
        end
        else
        begin
            shifted   = ext >> align_sh[4:0];
            lost_mask = (27'd1 << align_sh[4:0]) - 27'd1;
            sticky    = |(ext & lost_mask);
        end
        if (align_sh < 8'd27)
        begin
            lost_mask = (27'd1 << align_sh[4:0]) - 27'd1;
        end
        else
        begin
            lost_mask = '1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[1])
        begin
            wrap2_reg  <= y1[31] && (y1[30:0] > MAG_135) && (y1[30:0] <= MAG_INF);
            inf2_reg   <= (ea == 8'hFF);
            sign2_reg  <= a_big;
            big2_reg   <= big_m;
            small2_reg <= {shifted[26:1], shifted[0] | sticky};
            exp2_reg   <= big_e;
        end
        if (adv[2])
        begin
            wrap3_reg <= wrap2_reg;
            inf3_reg  <= inf2_reg;
            sign3_reg <= sign2_reg;
            diff3_reg <= {big2_reg, 3'b000} - small2_reg;
            exp3_reg  <= exp2_reg;
        end
    end

    // Stage 4 logic: priority encoder on the difference.
    logic [4:0] lzc;
    always_comb
    begin
        lzc = 5'd0;
        for (int i = 0; i < 27; i++)
        begin
            if (diff3_reg[i])
            begin
                lzc = 5'(26 - i);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[3])
        begin
            wrap4_reg <= wrap3_reg;
            inf4_reg  <= inf3_reg;
            sign4_reg <= sign3_reg;
            zero4_reg <= (diff3_reg == '0);
            diff4_reg <= diff3_reg;
            exp4_reg  <= exp3_reg;
            lzc4_reg  <= lzc;
        end
    end

    // Stage 5 logic: normalize and round to nearest even.
    logic [26:0] norm;
    logic        round_up;
    logic [24:0] mant_r;
    logic [7:0]  exp_r;
    logic [31:0] sum_bits;
    logic [31:0] yaw_out;

    always_comb
    begin
        norm     = diff4_reg << lzc4_reg;
        round_up = norm[2] && (norm[1] || norm[0] || norm[3]);
        mant_r   = {1'b0, norm[26:3]} + {24'd0, round_up};
        if (mant_r[24])
        begin
            exp_r    = exp4_reg - {3'd0, lzc4_reg} + 8'd1;
            sum_bits = {sign4_reg, exp_r, 23'd0};
        end
        else
        begin
            exp_r    = exp4_reg - {3'd0, lzc4_reg};
            sum_bits = {sign4_reg, exp_r, mant_r[22:0]};
        end
        if (!wrap4_reg || inf4_reg)
        begin
            yaw_out = pay_reg[3].yaw_bits;
        end
        else if (zero4_reg)
        begin
            yaw_out = 32'd0;
        end
        else
        begin
            yaw_out = sum_bits;
        end
    end

    logic [31:0] yaw5_reg;
    always_ff @(posedge clk)
    begin
        if (adv[4])
        begin
            yaw5_reg <= yaw_out;
        end
    end

    always_comb
    begin
        out_data          = pay_reg[4];
        out_data.yaw_bits = yaw5_reg;
    end

    assign in_ready  = adv[0];
    assign out_valid = vld_reg[4];
endmodule
